FILE: rtl/mmoc_pkg.sv
// Shared types, widths and helpers for the median/MAD outlier clip block.
// No dependencies; used by mmoc_amp and median_mad_outlier_clip_top.
package mmoc_pkg;

    localparam int AMP_W    = 24;   // Q16.8 amplitude
    localparam int SQ_W     = 32;   // re^2 + im^2
    localparam int WGT_W    = 16;   // Q8.8 weight
    localparam int THR_W    = 16;   // Q8.8 clip multiple
    localparam int CUT_W    = THR_W + AMP_W;
    localparam int FLAG_W   = 7;
    localparam int SAMPLE_W = 112;  // u, v, real, imag, weight
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 120;
    localparam int OUT_USER_W = 2;

    localparam logic [THR_W-1:0] THR_RESET = 16'd1280;
    localparam logic [WGT_W-1:0] WGT_ONE   = 16'd256;

    // Control between the sequencer and the amplitude unit
    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] sum_sq;
        logic [WGT_W-1:0] weight;
    } amp_req_t;

    typedef struct packed {
        logic             done;
        logic [AMP_W-1:0] amp;
    } amp_rsp_t;

    function automatic logic [AMP_W-1:0] abs_diff(input logic [AMP_W-1:0] a,
                                                  input logic [AMP_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

FILE: rtl/mmoc_amp.sv
// Amplitude unit: floor(isqrt(s << 32) / w), saturated to Q16.8.
// Bit-serial square root (32 steps) then restoring divide (32 steps). Uses mmoc_pkg.
module mmoc_amp import mmoc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  amp_req_t req,
    output amp_rsp_t rsp
);

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_SQRT = 3'b010,
        A_DIV  = 3'b100
    } amp_state_t;

    amp_state_t        state_reg, state_next;
    logic [4:0]        step_reg, step_next;
    logic [31:0]       x_reg, x_next;
    logic [35:0]       rem_reg, rem_next;
    logic [31:0]       root_reg, root_next;
    logic [31:0]       dvd_reg, dvd_next;
    logic [15:0]       drem_reg, drem_next;
    logic [WGT_W-1:0]  div_reg, div_next;
    logic              done_reg, done_next;
    logic [AMP_W-1:0]  amp_reg, amp_next;

    logic [35:0] rem_sh, trial;
    logic        sq_ge;
    logic [16:0] dsh;
    logic        dv_ge;

    // one root digit and one quotient bit per step
    always_comb begin
        rem_sh = {rem_reg[33:0], x_reg[31:30]};
        trial  = {2'b00, root_reg, 2'b01};
        sq_ge  = (rem_sh >= trial);
        dsh    = {drem_reg, dvd_reg[31]};
        dv_ge  = (dsh >= {1'b0, div_reg});
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        dvd_next   = dvd_reg;
        drem_next  = drem_reg;
        div_next   = div_reg;
        done_next  = 1'b0;
        amp_next   = amp_reg;
        case (state_reg)
            A_IDLE: begin
                if (req.start) begin
                    x_next     = req.sum_sq;
                    rem_next   = '0;
                    root_next  = '0;
                    div_next   = (req.weight == '0) ? WGT_ONE : req.weight;
                    step_next  = '0;
                    state_next = A_SQRT;
                end
            end
            A_SQRT: begin
                x_next    = {x_reg[29:0], 2'b00};
                rem_next  = sq_ge ? (rem_sh - trial) : rem_sh;
                root_next = {root_reg[30:0], sq_ge};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31) begin
                    dvd_next   = {root_reg[30:0], sq_ge};
                    drem_next  = '0;
                    state_next = A_DIV;
                end
            end
            A_DIV: begin
                drem_next = dv_ge ? 16'(dsh - {1'b0, div_reg}) : dsh[15:0];
                dvd_next  = {dvd_reg[30:0], dv_ge};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31) begin
                    amp_next   = (|dvd_reg[30:23]) ? {AMP_W{1'b1}}
                                                   : {dvd_reg[22:0], dv_ge};
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
            end
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        step_reg <= step_next;
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        dvd_reg  <= dvd_next;
        drem_reg <= drem_next;
        div_reg  <= div_next;
        amp_reg  <= amp_next;
    end

    assign rsp.done = done_reg;
    assign rsp.amp  = amp_reg;

endmodule

FILE: rtl/median_mad_outlier_clip_top.sv
// Median/MAD outlier clip, top level: sample store, rank-count sequencer, replay.
// Depends on mmoc_pkg and mmoc_amp.
//
// Samples are loaded one beat at a time; each beat is squared on the shared multiplier
// and passed through the amplitude unit (32 root steps, 32 divide steps) before the
// next beat is taken. The beat with tlast then starts the median search: every stored
// amplitude is a candidate whose rank is counted against all n stored amplitudes
// through the single read port of the amplitude memory; the MAD search then does the
// same on the deviations from the median. Each search stops once both middle ranks
// are found. Replay then sends one result beat per stored sample, held through output
// stalls. s_axis_tready is low while any of this runs.
// Samples past MAX_SAMPLES are dropped; the stores need no clearing after reset.
module median_mad_outlier_clip_top import mmoc_pkg::*; #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [THR_W-1:0]      cfg_wr_data,   // clip_threshold
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // u_coord[31:0], v_coord[63:32], vis_real[79:64], vis_imag[95:80], weight[111:96]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,  // last_sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_u[31:0], out_v[63:32], out_real[79:64], out_imag[95:80],
    // out_weight[111:96], flagged_count[118:112], zero pad [119]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // keep[0], no_flagging[1]
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    output logic                  m_axis_tlast   // last_result
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_SQR   = 11'b00000000010,
        S_AMP   = 11'b00000000100,
        S_CAND  = 11'b00000001000,
        S_CWAIT = 11'b00000010000,
        S_SCAN  = 11'b00000100000,
        S_NEXT  = 11'b00001000000,
        S_CUT   = 11'b00010000000,
        S_RISS  = 11'b00100000000,
        S_RWAIT = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [THR_W-1:0]  thr_reg, thr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              last_reg, last_next;
    logic [15:0]       re_reg, im_reg, re_next, im_next;
    logic [WGT_W-1:0]  w_reg, w_next;
    logic              sq_sel_reg, sq_sel_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic              mad_ph_reg, mad_ph_next;
    logic [CW-1:0]     i_reg, i_next, j_reg, j_next;
    logic              pend_reg, pend_next;
    logic [CW-1:0]     less_reg, less_next, leq_reg, leq_next;
    logic [AMP_W-1:0]  cand_reg, cand_next;
    logic [AMP_W-1:0]  vlo_reg, vlo_next, vhi_reg, vhi_next;
    logic              flo_reg, flo_next, fhi_reg, fhi_next;
    logic [AMP_W-1:0]  med_reg, med_next, mad_reg, mad_next;
    logic [CUT_W-1:0]  cut_reg, cut_next;
    logic [FLAG_W-1:0] flag_reg, flag_next;
    logic              mv_reg, mv_next;
    logic [OUT_DATA_W-1:0] md_reg, md_next;
    logic [OUT_USER_W-1:0] mu_reg, mu_next;
    logic              ml_reg, ml_next;

    // memories
    logic [SAMPLE_W-1:0] smp_mem [MAX_SAMPLES];
    logic [AMP_W-1:0]    amp_mem [MAX_SAMPLES];
    logic [SAMPLE_W-1:0] smp_rd_reg;
    logic [AMP_W-1:0]    amp_rd_reg;
    logic [AW-1:0]       rd_addr;
    logic                smp_we, amp_we;

    amp_req_t amp_req;
    amp_rsp_t amp_rsp;

    // shared multiplier
    logic [AMP_W-1:0]  mul_a;
    logic [WGT_W-1:0]  mul_b;
    logic [CUT_W-1:0]  mul_p;

    logic              s_acc, m_acc;
    logic [AMP_W-1:0]  scan_val, dev;
    logic [CW-1:0]     k_lo, k_hi;
    logic              hit_lo, hit_hi, keep;
    logic [AMP_W:0]    mid_sum;
    logic [15:0]       re_abs, im_abs;

    mmoc_amp u_amp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (amp_req),
        .rsp     (amp_rsp)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = mv_reg && m_axis_tready;

    assign re_abs = re_reg[15] ? 16'(-re_reg) : re_reg;
    assign im_abs = im_reg[15] ? 16'(-im_reg) : im_reg;

    assign mul_p = CUT_W'(mul_a) * CUT_W'(mul_b);

    // rank targets: both middle ranks, equal for odd n
    assign k_lo = (count_reg - CW'(1)) >> 1;
    assign k_hi = count_reg >> 1;
    assign hit_lo = (less_reg <= k_lo) && (k_lo < leq_reg);
    assign hit_hi = (less_reg <= k_hi) && (k_hi < leq_reg);
    assign mid_sum = {1'b0, (hit_lo ? cand_reg : vlo_reg)}
                   + {1'b0, (hit_hi ? cand_reg : vhi_reg)};

    assign scan_val = mad_ph_reg ? abs_diff(amp_rd_reg, med_reg) : amp_rd_reg;
    assign dev  = abs_diff(amp_rd_reg, med_reg);
    assign keep = (mad_reg == '0) || !({{(CUT_W-AMP_W-8){1'b0}}, dev, 8'h00} > cut_reg);

    // sequencer
    always_comb begin
        state_next  = state_reg;
        thr_next    = cfg_wr_en ? cfg_wr_data : thr_reg;
        count_next  = count_reg;
        last_next   = last_reg;
        re_next     = re_reg;
        im_next     = im_reg;
        w_next      = w_reg;
        sq_sel_next = sq_sel_reg;
        sq_next     = sq_reg;
        mad_ph_next = mad_ph_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        pend_next   = 1'b0;
        less_next   = less_reg;
        leq_next    = leq_reg;
        cand_next   = cand_reg;
        vlo_next    = vlo_reg;
        vhi_next    = vhi_reg;
        flo_next    = flo_reg;
        fhi_next    = fhi_reg;
        med_next    = med_reg;
        mad_next    = mad_reg;
        cut_next    = cut_reg;
        flag_next   = flag_reg;
        mv_next     = mv_reg;
        md_next     = md_reg;
        mu_next     = mu_reg;
        ml_next     = ml_reg;
        smp_we      = 1'b0;
        amp_we      = 1'b0;
        rd_addr     = i_reg[AW-1:0];
        mul_a       = {{(AMP_W-16){1'b0}}, re_abs};
        mul_b       = re_abs;
        amp_req.start  = 1'b0;
        amp_req.sum_sq = sq_reg;
        amp_req.weight = w_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    last_next = s_axis_tlast;
                    re_next   = s_axis_tdata[79:64];
                    im_next   = s_axis_tdata[95:80];
                    w_next    = s_axis_tdata[111:96];
                    if (count_reg < MAX_CNT) begin
                        smp_we      = 1'b1;
                        sq_sel_next = 1'b0;
                        state_next  = S_SQR;
                    end else if (s_axis_tlast) begin
                        mad_ph_next = 1'b0;
                        i_next      = '0;
                        flo_next    = 1'b0;
                        fhi_next    = 1'b0;
                        state_next  = S_CAND;
                    end
                end
            end
            S_SQR: begin
                if (!sq_sel_reg) begin
                    sq_next     = SQ_W'(mul_p);
                    sq_sel_next = 1'b1;
                end else begin
                    mul_a      = {{(AMP_W-16){1'b0}}, im_abs};
                    mul_b      = im_abs;
                    sq_next    = sq_reg + SQ_W'(mul_p);
                    state_next = S_AMP;
                end
            end
            S_AMP: begin
                amp_req.start = !sq_sel_reg ? 1'b0 : 1'b1;
                sq_sel_next   = 1'b0;
                if (amp_rsp.done) begin
                    amp_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                    if (last_reg) begin
                        mad_ph_next = 1'b0;
                        i_next      = '0;
                        flo_next    = 1'b0;
                        fhi_next    = 1'b0;
                        state_next  = S_CAND;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_CAND: begin
                rd_addr    = i_reg[AW-1:0];
                state_next = S_CWAIT;
            end
            S_CWAIT: begin
                cand_next  = scan_val;
                j_next     = '0;
                less_next  = '0;
                leq_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                rd_addr = j_reg[AW-1:0];
                if (j_reg < count_reg) begin
                    j_next    = j_reg + CW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    less_next = less_reg + CW'(scan_val < cand_reg);
                    leq_next  = leq_reg + CW'(scan_val <= cand_reg);
                end
                if (!(j_reg < count_reg) && !pend_reg) state_next = S_NEXT;
            end
            S_NEXT: begin
                if (hit_lo) begin
                    vlo_next = cand_reg;
                    flo_next = 1'b1;
                end
                if (hit_hi) begin
                    vhi_next = cand_reg;
                    fhi_next = 1'b1;
                end
                if ((flo_reg || hit_lo) && (fhi_reg || hit_hi)) begin
                    i_next   = '0;
                    flo_next = 1'b0;
                    fhi_next = 1'b0;
                    if (!mad_ph_reg) begin
                        med_next    = mid_sum[AMP_W:1];
                        mad_ph_next = 1'b1;
                        state_next  = S_CAND;
                    end else begin
                        mad_next   = mid_sum[AMP_W:1];
                        state_next = S_CUT;
                    end
                end else begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_CAND;
                end
            end
            S_CUT: begin
                mul_a      = mad_reg;
                mul_b      = thr_reg;
                cut_next   = mul_p;
                i_next     = '0;
                flag_next  = '0;
                state_next = S_RISS;
            end
            S_RISS: begin
                rd_addr    = i_reg[AW-1:0];
                state_next = S_RWAIT;
            end
            S_RWAIT: begin
                ml_next   = (i_reg == count_reg - CW'(1));
                flag_next = flag_reg + FLAG_W'(!keep);
                md_next   = {1'b0,
                             (ml_next ? FLAG_W'(flag_reg + FLAG_W'(!keep)) : FLAG_W'(0)),
                             smp_rd_reg};
                mu_next   = {(mad_reg == '0), keep};
                mv_next   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_acc) begin
                    mv_next = 1'b0;
                    if (ml_reg) begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end else begin
                        i_next     = i_reg + CW'(1);
                        state_next = S_RISS;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sample and amplitude memories
    always_ff @(posedge aclk) begin
        if (smp_we) smp_mem[count_reg[AW-1:0]] <= s_axis_tdata[SAMPLE_W-1:0];
        smp_rd_reg <= smp_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (amp_we) amp_mem[count_reg[AW-1:0]] <= amp_rsp.amp;
        amp_rd_reg <= amp_mem[rd_addr];
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            thr_reg   <= THR_RESET;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            thr_reg   <= thr_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            mv_reg    <= mv_next;
        end
        last_reg   <= last_next;
        re_reg     <= re_next;
        im_reg     <= im_next;
        w_reg      <= w_next;
        sq_sel_reg <= sq_sel_next;
        sq_reg     <= sq_next;
        mad_ph_reg <= mad_ph_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        less_reg   <= less_next;
        leq_reg    <= leq_next;
        cand_reg   <= cand_next;
        vlo_reg    <= vlo_next;
        vhi_reg    <= vhi_next;
        flo_reg    <= flo_next;
        fhi_reg    <= fhi_next;
        med_reg    <= med_next;
        mad_reg    <= mad_next;
        cut_reg    <= cut_next;
        flag_reg   <= flag_next;
        md_reg     <= md_next;
        mu_reg     <= mu_next;
        ml_reg     <= ml_next;
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = md_reg;
    assign m_axis_tuser  = mu_reg;
    assign m_axis_tlast  = ml_reg;

endmodule

FILE: bench/tb.sv
// Testbench for median_mad_outlier_clip_top: loads sample sets, predicts the replayed
// keep/flag results with a behavioral median/MAD clipper and checks every beat.
// Depends on mmoc_pkg and the RTL of median_mad_outlier_clip_top.
`timescale 1ns / 100ps

module tb import mmoc_pkg::*; ();

    localparam int CAP = 64;
    localparam longint CYCLE_LIMIT = 3_000_000;

    // packed with u in the lowest bits, matching the tdata layout
    typedef struct packed {
        logic [15:0] wgt;
        logic [15:0] im;
        logic [15:0] re;
        logic [31:0] v;
        logic [31:0] u;
    } vis_t;

    typedef struct packed {
        vis_t        s;
        logic        keep;
        logic [6:0]  nflag;
        logic        nof;
        logic        last;
    } clip_res_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [THR_W-1:0] cfg_wr_data = '0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tlast = 0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic m_axis_tlast;

    // predictor state
    vis_t        set_buf[CAP];
    logic [23:0] amp_buf[CAP];
    int          set_len = 0;
    logic [15:0] thresh = THR_RESET;
    clip_res_t   expected_q[$];

    int  errors = 0;
    bit  idle_on = 1;
    bit  sink_idle_on = 1;
    longint cycles = 0;

    median_mad_outlier_clip_top #(.MAX_SAMPLES(CAP)) i_dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [23:0] sample_amp(input vis_t s);
        longint re, im;
        logic [63:0] sq, a, w;
        re = longint'($signed(s.re));
        im = longint'($signed(s.im));
        sq = re * re + im * im;
        w = (s.wgt == 0) ? 64'd256 : 64'(s.wgt);
        a = root64(sq << 32) / w;
        return (a > 64'hFFFFFF) ? 24'hFFFFFF : a[23:0];
    endfunction

    function automatic logic [23:0] median_of(input logic [23:0] vals[$]);
        logic [24:0] m;
        vals.sort();
        if (vals.size() % 2) return vals[vals.size() / 2];
        m = 25'(vals[vals.size() / 2 - 1]) + 25'(vals[vals.size() / 2]);
        return m[24:1];
    endfunction

    function automatic logic [23:0] absdev(input logic [23:0] a, input logic [23:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // store one sample; on the last one, queue the replay of the whole set
    task automatic predict_clip(input vis_t s, input bit last);
        logic [23:0] vals[$];
        logic [23:0] med, mad;
        logic [6:0]  nfl;
        clip_res_t   r;
        if (set_len < CAP) begin
            set_buf[set_len] = s;
            amp_buf[set_len] = sample_amp(s);
            set_len++;
        end
        if (!last || set_len == 0) begin
            if (last) set_len = 0;
            return;
        end
        for (int i = 0; i < set_len; i++) vals.push_back(amp_buf[i]);
        med = median_of(vals);
        vals.delete();
        for (int i = 0; i < set_len; i++) vals.push_back(absdev(amp_buf[i], med));
        mad = median_of(vals);
        nfl = 0;
        for (int i = 0; i < set_len; i++) begin
            r.s = set_buf[i];
            r.keep = 1;
            if (mad != 0 && (40'(absdev(amp_buf[i], med)) << 8) > 40'(thresh) * 40'(mad))
                r.keep = 0;
            if (!r.keep) nfl++;
            r.nof = (mad == 0);
            r.last = (i == set_len - 1);
            r.nflag = r.last ? nfl : 7'd0;
            expected_q.push_back(r);
        end
        set_len = 0;
    endtask

    // result checker and sink-side idling
    always @(posedge aclk) begin
        clip_res_t exp_r, got;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.s = m_axis_tdata[111:0];
                got.nflag = m_axis_tdata[118:112];
                got.keep = m_axis_tuser[0];
                got.nof = m_axis_tuser[1];
                got.last = m_axis_tlast;
                if (expected_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result beat %h", got);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp u=%h v=%h re=%h im=%h w=%h keep=%b ",
                                      "cnt=%0d nof=%b last=%b | got u=%h v=%h re=%h ",
                                      "im=%h w=%h keep=%b cnt=%0d nof=%b last=%b"},
                                exp_r.s.u, exp_r.s.v, exp_r.s.re, exp_r.s.im, exp_r.s.wgt,
                                exp_r.keep, exp_r.nflag, exp_r.nof, exp_r.last,
                                got.s.u, got.s.v, got.s.re, got.s.im, got.s.wgt,
                                got.keep, got.nflag, got.nof, got.last);
                    end
                end
            end
            m_axis_tready <= !(sink_idle_on && $urandom_range(99) < 32);
        end
    end

    // send one sample beat, with random idle cycles ahead of it
    task automatic send_sample(input vis_t s, input bit last);
        while (idle_on && $urandom_range(99) < 32) @(posedge aclk);
        s_axis_tvalid <= 1;
        s_axis_tdata <= s;
        s_axis_tlast <= last;
        do @(posedge aclk); while (!s_axis_tready);
        predict_clip(s, last);
        s_axis_tvalid <= 0;
        @(posedge aclk);
    endtask

    task automatic wait_drain();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [15:0] val);
        wait_drain();
        cfg_wr_en <= 1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        thresh = val;
        @(posedge aclk);
    endtask

    function automatic vis_t rand_sample();
        vis_t s;
        s.u = $urandom;
        s.v = $urandom;
        s.wgt = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(512, 128));
        if ($urandom_range(4) == 0) begin
            s.re = 16'($urandom);
            s.im = 16'($urandom);
        end else begin
            s.re = 16'($signed($urandom_range(400)) - 200);
            s.im = 16'($signed($urandom_range(400)) - 200);
        end
        return s;
    endfunction

    function automatic vis_t mk(input logic [15:0] re, input logic [15:0] im,
                                input logic [15:0] w);
        vis_t s;
        s.u = $urandom;
        s.v = $urandom;
        s.re = re;
        s.im = im;
        s.wgt = w;
        return s;
    endfunction

    // field extremes, zero weight, saturation, single-sample set
    task automatic test_extremes();
        send_sample(mk(16'h8000, 16'h8000, 16'd0), 0);
        send_sample(mk(16'h7FFF, 16'h7FFF, 16'd1), 0);
        send_sample(mk(16'h0000, 16'h0000, 16'hFFFF), 0);
        send_sample('{u: 32'h8000_0000, v: 32'h7FFF_FFFF, re: 16'd3, im: 16'd4,
                      wgt: 16'd256}, 0);
        send_sample('{u: 32'hFFFF_FFFF, v: 32'h0, re: 16'd10, im: 16'd0,
                      wgt: 16'd256}, 1);
        send_sample(mk(16'd5, 16'd5, 16'd256), 1);
    endtask

    // outliers in an odd and an even set; equal amplitudes give zero MAD
    task automatic test_outliers();
        for (int i = 0; i < 6; i++) send_sample(mk(16'(100 + i), 16'd0, 16'd256), 0);
        send_sample(mk(16'd30000, 16'd0, 16'd256), 1);
        for (int i = 0; i < 5; i++) send_sample(mk(16'(50 + 2 * i), 16'd0, 16'd256), 0);
        send_sample(mk(16'd1, 16'd0, 16'd256), 1);
        for (int i = 0; i < 4; i++) send_sample(mk(16'd7, 16'd0, 16'd256), i == 3);
    endtask

    // overflow past capacity, then the replay still happens
    task automatic test_capacity();
        for (int i = 0; i < CAP + 3; i++) send_sample(rand_sample(), i == CAP + 2);
    endtask

    task automatic test_random_sets(input int total);
        int sent = 0, len;
        while (sent < total) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(8, 1);
            for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
            sent += len;
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_extremes();
        test_outliers();
        write_threshold(16'd0);
        test_outliers();
        write_threshold(16'hFFFF);
        test_outliers();
        test_capacity();
        write_threshold(16'd384);
        // no idling for a stretch
        idle_on = 0;
        sink_idle_on = 0;
        test_random_sets(30);
        idle_on = 1;
        sink_idle_on = 1;
        test_random_sets(40);
        wait_drain();
        write_threshold(THR_RESET);
        test_random_sets(40);
        wait_drain();
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
